>>> hdl/dfr_pkg.sv
`timescale 1ns / 1ps
// Package for the datagram and debug packet deframer: sizes, event codes,
// the classified-byte and result records, and the hex digit decoder.
// No dependencies.
package dfr_pkg;

  localparam int unsigned PAYLOAD_MAX = 384;
  localparam int unsigned CONTROL_MAX = 24;

  localparam int unsigned PCNT_W = $clog2(PAYLOAD_MAX + 1);
  localparam int unsigned CCNT_W = $clog2(CONTROL_MAX + 1);

  localparam logic [15:0] MAX_LEN_RESET = 16'd512;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_INTR   = 8'h03;
  localparam logic [7:0] CH_CTRL   = 8'h01;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // Depth of the two small queues
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PKT_OK = 3'd1,
    EV_INTR   = 3'd2,
    EV_CTRL   = 3'd3,
    EV_RESYNC = 3'd4
  } event_e;

  // Byte as classified by the header side
  typedef struct packed {
    event_e              ev;
    logic [7:0]          data;
    logic                cw;
    logic [CCNT_W-1:0]   ci;
    logic [CCNT_W-1:0]   clen;
    logic                dbg;
  } item_t;

  // One finished result
  typedef struct packed {
    event_e              ev;
    logic [7:0]          data;
    logic                pw;
    logic [PCNT_W-1:0]   pi;
    logic                cw;
    logic [CCNT_W-1:0]   ci;
    logic [PCNT_W-1:0]   plen;
    logic [CCNT_W-1:0]   clen;
    logic                dbg;
  } result_t;

  // Hex digit value; anything that is not a hex digit reads as all ones
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30;
    end else if (l >= 8'h61 && l <= 8'h66) begin
      return l - 8'h61 + 8'd10;
    end else begin
      return 8'hFF;
    end
  endfunction

endpackage

>>> hdl/dfr_front.sv
`timescale 1ns / 1ps
// Header side: tracks datagram framing and control capture, tags each byte.
// Depends on dfr_pkg.
module dfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output dfr_pkg::item_t item_o
);
  import dfr_pkg::*;

  typedef enum logic [2:0] {
    HDR_LOW  = 3'b001,
    HDR_HIGH = 3'b010,
    HDR_BODY = 3'b100
  } hdr_state_e;

  hdr_state_e        hdr_q, hdr_d;
  logic [15:0]       max_len_q;
  logic [7:0]        len_low_q, len_low_d;
  logic [15:0]       left_q, left_d;
  logic              first_q, first_d;
  logic              ctrl_q, ctrl_d;
  logic [CCNT_W-1:0] ccnt_q, ccnt_d;

  logic [15:0]       len;
  logic [15:0]       left_dec;
  logic              is_ctrl;

  always_comb begin
    hdr_d     = hdr_q;
    len_low_d = len_low_q;
    left_d    = left_q;
    first_d   = first_q;
    ctrl_d    = ctrl_q;
    ccnt_d    = ccnt_q;
    len       = {rx_byte_i, len_low_q};
    left_dec  = left_q - 16'd1;
    is_ctrl   = first_q ? (rx_byte_i == CH_CTRL) : ctrl_q;

    item_o      = '0;
    item_o.ev   = EV_NONE;
    item_o.data = rx_byte_i;

    unique case (hdr_q)
      HDR_LOW: begin
        len_low_d = rx_byte_i;
        hdr_d     = HDR_HIGH;
      end
      HDR_HIGH: begin
        first_d = 1'b1;
        ccnt_d  = '0;
        if (len > max_len_q) begin
          item_o.ev = EV_RESYNC;
          left_d    = '0;
          hdr_d     = HDR_LOW;
        end else begin
          left_d = len;
          hdr_d  = (len != 16'd0) ? HDR_BODY : HDR_LOW;
        end
      end
      HDR_BODY: begin
        left_d  = left_dec;
        ctrl_d  = is_ctrl;
        first_d = 1'b0;
        if (is_ctrl) begin
          if (ccnt_q < CCNT_W'(CONTROL_MAX)) begin
            item_o.cw = 1'b1;
            item_o.ci = ccnt_q;
            ccnt_d    = ccnt_q + CCNT_W'(1);
          end
          if (left_dec == 16'd0 && ccnt_d > CCNT_W'(1)) begin
            item_o.ev   = EV_CTRL;
            item_o.clen = ccnt_d;
          end
        end else begin
          item_o.dbg = 1'b1;
        end
        if (left_dec == 16'd0) begin
          hdr_d = HDR_LOW;
        end
      end
      default: hdr_d = HDR_LOW;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q     <= HDR_LOW;
      max_len_q <= MAX_LEN_RESET;
      len_low_q <= '0;
      left_q    <= '0;
      first_q   <= 1'b0;
      ctrl_q    <= 1'b0;
      ccnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (accept_i) begin
        hdr_q     <= hdr_d;
        len_low_q <= len_low_d;
        left_q    <= left_d;
        first_q   <= first_d;
        ctrl_q    <= ctrl_d;
        ccnt_q    <= ccnt_d;
      end
    end
  end

endmodule

>>> hdl/dfr_queue.sv
`timescale 1ns / 1ps
// Short queue of classified bytes between the header and packet sides.
// Depends on dfr_pkg.
module dfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dfr_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dfr_pkg::item_t item_o
);
  import dfr_pkg::*;

  item_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + Q_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hdl/dfr_back.sv
`timescale 1ns / 1ps
// Packet side: '$' payload '#' checksum parser and the result queue.
// Depends on dfr_pkg.
module dfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dfr_pkg::item_t   item_i,
  output logic             take_o,
  output logic             empty_o,
  input  logic             pop_i,
  output dfr_pkg::result_t res_o
);
  import dfr_pkg::*;

  typedef enum logic [3:0] {
    PP_IDLE = 4'b0001,
    PP_DATA = 4'b0010,
    PP_SUMH = 4'b0100,
    PP_SUML = 4'b1000
  } pkt_state_e;

  pkt_state_e        pp_q, pp_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        sumh_q, sumh_d;
  logic [7:0]        digit;
  result_t           res;

  result_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               out_full;
  logic               out_pop;

  assign out_full = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign take_o   = valid_i && !out_full;
  assign empty_o  = (cnt_q == '0);
  assign out_pop  = pop_i && !empty_o;
  assign res_o    = mem_q[rd_q];

  always_comb begin
    pp_d   = pp_q;
    pcnt_d = pcnt_q;
    sum_d  = sum_q;
    sumh_d = sumh_q;
    digit  = hex_digit(item_i.data);

    res      = '0;
    res.ev   = item_i.ev;
    res.data = item_i.data;
    res.cw   = item_i.cw;
    res.ci   = item_i.ci;
    res.clen = item_i.clen;
    res.dbg  = item_i.dbg;

    if (item_i.dbg) begin
      unique case (pp_q)
        PP_IDLE: begin
          if (item_i.data == CH_DOLLAR) begin
            pp_d   = PP_DATA;
            pcnt_d = '0;
            sum_d  = '0;
          end else if (item_i.data == CH_INTR) begin
            res.ev = EV_INTR;
          end
        end
        PP_DATA: begin
          if (item_i.data == CH_HASH) begin
            pp_d = PP_SUMH;
          end else begin
            sum_d = sum_q + item_i.data;
            // hold the count at the limit, keep summing
            if (pcnt_q < PCNT_W'(PAYLOAD_MAX)) begin
              res.pw = 1'b1;
              res.pi = pcnt_q;
              pcnt_d = pcnt_q + PCNT_W'(1);
            end
          end
        end
        PP_SUMH: begin
          sumh_d = {digit[3:0], 4'h0};
          pp_d   = PP_SUML;
        end
        PP_SUML: begin
          pp_d = PP_IDLE;
          if ((sumh_q | digit) == sum_q) begin
            res.ev   = EV_PKT_OK;
            res.plen = pcnt_q;
          end
        end
        default: pp_d = PP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      mem_q[wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= PP_IDLE;
      pcnt_q <= '0;
      sum_q  <= '0;
      sumh_q <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (take_o) begin
        pp_q   <= pp_d;
        pcnt_q <= pcnt_d;
        sum_q  <= sum_d;
        sumh_q <= sumh_d;
        wr_q   <= wr_q + Q_PTR_W'(1);
      end
      if (out_pop) begin
        rd_q <= rd_q + Q_PTR_W'(1);
      end
      case ({take_o, out_pop})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hdl/datagram_and_debug_packet_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the datagram and debug packet deframer.
// Depends on dfr_pkg, dfr_front, dfr_queue and dfr_back.
//
//   Channel   Direction  Handshake                 Carries
//   ------    ---------  ------------------------  ------------------------------
//   input     in         push / full               rx_byte_i
//   results   out        empty / pop               event_res_o .. debug_byte_seen_o
//   config    in         cfg_valid_i / cfg_ready_o max_datagram_length (16 bits)
//
// One byte is taken per cycle while full is low; the middle queue registers it,
// the packet side moves it into the result queue when that has room, and from
// there it is on the result ports, ready to pop. The header side advances once
// per cycle while bytes are accepted, the packet side while it takes items.
// Reset clears all framing and packet state and sets the length limit to 512.
// A stalled result side fills the result queue, then the middle queue, and only
// then raises full; the config port is always ready.
module datagram_and_debug_packet_deframer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte input
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 rx_byte_i,
  // results
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 event_res_o,
  output logic [7:0]                 data_byte_o,
  output logic                       payload_write_o,
  output logic [dfr_pkg::PCNT_W-1:0] payload_index_o,
  output logic                       ctrl_write_o,
  output logic [dfr_pkg::CCNT_W-1:0] ctrl_index_o,
  output logic [dfr_pkg::PCNT_W-1:0] packet_length_o,
  output logic [dfr_pkg::CCNT_W-1:0] ctrl_length_o,
  output logic                       debug_byte_seen_o,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [15:0]                cfg_data_i
);
  import dfr_pkg::*;

  logic    accept;
  item_t   front_item;
  item_t   mid_item;
  logic    mid_valid;
  logic    mid_take;
  result_t res;

  // take a request whenever the middle queue has room
  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  dfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .item_o     (front_item)
  );

  // middle queue: decouple header parsing from the packet parser
  dfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_take),
    .valid_o (mid_valid),
    .item_o  (mid_item)
  );

  dfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .item_i  (mid_item),
    .take_o  (mid_take),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res)
  );

  // unpack the oldest waiting result onto the ports
  assign event_res_o       = res.ev;
  assign data_byte_o       = res.data;
  assign payload_write_o   = res.pw;
  assign payload_index_o   = res.pi;
  assign ctrl_write_o      = res.cw;
  assign ctrl_index_o      = res.ci;
  assign packet_length_o   = res.plen;
  assign ctrl_length_o     = res.clen;
  assign debug_byte_seen_o = res.dbg;

endmodule

>>> hdl/dfr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the deframer top level, bound onto it below.
// Depends on dfr_pkg and datagram_and_debug_packet_deframer_top.
module dfr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       empty,
  input logic                       pop,
  input logic [2:0]                 event_res_o,
  input logic [7:0]                 data_byte_o,
  input logic                       payload_write_o,
  input logic [dfr_pkg::PCNT_W-1:0] payload_index_o,
  input logic                       ctrl_write_o,
  input logic                       debug_byte_seen_o
);
  import dfr_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_byte_o)))
    else $error("result changed while stalled");

  // payload bytes only come from debug datagrams
  a_pw_dbg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && payload_write_o) |-> debug_byte_seen_o)
    else $error("payload write outside a debug datagram");

  // a byte is never both payload and control
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(payload_write_o && ctrl_write_o))
    else $error("payload and control write together");

  // index is zero unless a payload byte is written
  a_pidx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !payload_write_o) |-> (payload_index_o == '0))
    else $error("payload index without write");

  // control events never come from a debug byte
  a_ctrl_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && debug_byte_seen_o) |->
      (event_res_o != EV_CTRL && event_res_o != EV_RESYNC))
    else $error("control or resync event on a debug byte");

endmodule

bind datagram_and_debug_packet_deframer_top dfr_checker u_dfr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .empty             (empty),
  .pop               (pop),
  .event_res_o       (event_res_o),
  .data_byte_o       (data_byte_o),
  .payload_write_o   (payload_write_o),
  .payload_index_o   (payload_index_o),
  .ctrl_write_o      (ctrl_write_o),
  .debug_byte_seen_o (debug_byte_seen_o)
);

>>> test/deframer_monitor.sv
`timescale 1ns / 1ps
// Monitor for the datagram and debug packet deframer: watches the byte, result
// and config channels, predicts each result from the accepted bytes and compares.
// Depends on dfr_pkg.
module deframer_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       full,
  input  logic [7:0]                 rx_byte_i,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [2:0]                 event_res_o,
  input  logic [7:0]                 data_byte_o,
  input  logic                       payload_write_o,
  input  logic [dfr_pkg::PCNT_W-1:0] payload_index_o,
  input  logic                       ctrl_write_o,
  input  logic [dfr_pkg::CCNT_W-1:0] ctrl_index_o,
  input  logic [dfr_pkg::PCNT_W-1:0] packet_length_o,
  input  logic [dfr_pkg::CCNT_W-1:0] ctrl_length_o,
  input  logic                       debug_byte_seen_o,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_o,
  input  logic [15:0]                cfg_data_i,
  output int                         mismatch_count_o,
  output int                         awaited_count_o,
  output int                         checked_count_o
);
  import dfr_pkg::*;

  typedef enum logic [1:0] {HDR_LEN_LO, HDR_LEN_HI, HDR_BODY} hdr_phase_e;
  typedef enum logic [1:0] {PKT_IDLE, PKT_PAYLOAD, PKT_SUM_HI, PKT_SUM_LO} pkt_phase_e;

  // Shadow of the deframer state
  logic [15:0]       len_limit;
  hdr_phase_e        hdr_phase;
  logic [7:0]        len_lo;
  logic [15:0]       body_left;
  logic              body_first;
  logic              in_ctrl;
  logic [CCNT_W-1:0] ctrl_count;
  pkt_phase_e        pkt_phase;
  logic [PCNT_W-1:0] payload_count;
  logic [7:0]        payload_sum;
  logic [7:0]        sum_hi;

  result_t awaited_results[$];
  int      mismatches;
  int      checked;

  // Value of one checksum digit; a non-hex byte reads as all ones
  function automatic logic [7:0] hex_nibble_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | CASE_BIT;
    if (c >= "0" && c <= "9") return c - "0";
    if (folded >= "a" && folded <= "f") return folded - "a" + 8'd10;
    return 8'hFF;
  endfunction

  // Advance the shadow state by one byte and return the result it causes
  function automatic result_t deframe_byte(input logic [7:0] c);
    result_t    r;
    logic [15:0] dgram_len;
    logic [7:0]  nib;
    r      = '0;
    r.ev   = EV_NONE;
    r.data = c;
    case (hdr_phase)
      HDR_LEN_LO: begin
        len_lo    = c;
        hdr_phase = HDR_LEN_HI;
      end
      HDR_LEN_HI: begin
        dgram_len  = {c, len_lo};
        body_first = 1'b1;
        ctrl_count = '0;
        if (dgram_len > len_limit) begin
          r.ev      = EV_RESYNC;
          body_left = '0;
          hdr_phase = HDR_LEN_LO;
        end else begin
          body_left = dgram_len;
          hdr_phase = (dgram_len == 16'd0) ? HDR_LEN_LO : HDR_BODY;
        end
      end
      default: begin
        body_left = body_left - 16'd1;
        if (body_first) in_ctrl = (c == CH_CTRL);
        body_first = 1'b0;
        if (in_ctrl) begin
          if (ctrl_count < CONTROL_MAX) begin
            r.cw       = 1'b1;
            r.ci       = ctrl_count;
            ctrl_count = ctrl_count + 1'b1;
          end
          if (body_left == 16'd0 && ctrl_count > 1) begin
            r.ev   = EV_CTRL;
            r.clen = ctrl_count;
          end
        end else begin
          r.dbg = 1'b1;
          case (pkt_phase)
            PKT_IDLE: begin
              if (c == CH_DOLLAR) begin
                pkt_phase     = PKT_PAYLOAD;
                payload_count = '0;
                payload_sum   = '0;
              end else if (c == CH_INTR) begin
                r.ev = EV_INTR;
              end
            end
            PKT_PAYLOAD: begin
              if (c == CH_HASH) begin
                pkt_phase = PKT_SUM_HI;
              end else begin
                payload_sum = payload_sum + c;
                // past the payload buffer: sum only
                if (payload_count < PAYLOAD_MAX) begin
                  r.pw          = 1'b1;
                  r.pi          = payload_count;
                  payload_count = payload_count + 1'b1;
                end
              end
            end
            PKT_SUM_HI: begin
              nib       = hex_nibble_value(c);
              sum_hi    = {nib[3:0], 4'h0};
              pkt_phase = PKT_SUM_LO;
            end
            default: begin
              pkt_phase = PKT_IDLE;
              if ((sum_hi | hex_nibble_value(c)) == payload_sum) begin
                r.ev   = EV_PKT_OK;
                r.plen = payload_count;
              end
            end
          endcase
        end
        if (body_left == 16'd0) hdr_phase = HDR_LEN_LO;
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      len_limit     = MAX_LEN_RESET;
      hdr_phase     = HDR_LEN_LO;
      len_lo        = '0;
      body_left     = '0;
      body_first    = 1'b0;
      in_ctrl       = 1'b0;
      ctrl_count    = '0;
      pkt_phase     = PKT_IDLE;
      payload_count = '0;
      payload_sum   = '0;
      sum_hi        = '0;
      awaited_results.delete();
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual event %0d data %0d",
                   $time, event_res_o, data_byte_o);
        end else begin
          want = awaited_results.pop_front();
          checked++;
          compare_field("event_res", want.ev, event_res_o);
          compare_field("data_byte", want.data, data_byte_o);
          compare_field("payload_write", want.pw, payload_write_o);
          compare_field("payload_index", want.pi, payload_index_o);
          compare_field("ctrl_write", want.cw, ctrl_write_o);
          compare_field("ctrl_index", want.ci, ctrl_index_o);
          compare_field("packet_length", want.plen, packet_length_o);
          compare_field("ctrl_length", want.clen, ctrl_length_o);
          compare_field("debug_byte_seen", want.dbg, debug_byte_seen_o);
        end
      end
      // a byte accepted at this edge still sees the old limit
      if (push && !full) awaited_results.push_back(deframe_byte(rx_byte_i));
      if (cfg_valid_i && cfg_ready_o) len_limit = cfg_data_i;
    end
    awaited_count_o  = awaited_results.size();
    mismatch_count_o = mismatches;
    checked_count_o  = checked;
  end

endmodule

>>> test/tb_datagram_and_debug_packet_deframer_top.sv
`timescale 1ns / 1ps
// Testbench top for the datagram and debug packet deframer: drives byte, result
// and config channels and reports the verdict.
// Depends on dfr_pkg, datagram_and_debug_packet_deframer_top and deframer_monitor.
module tb_datagram_and_debug_packet_deframer_top;
  import dfr_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {PK_GOOD, PK_BAD_SUM, PK_WILD_DIGITS} pkt_flavor_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = 16'h0000;

  logic                full;
  logic                empty;
  logic [2:0]          event_res;
  logic [7:0]          data_byte;
  logic                payload_write;
  logic [PCNT_W-1:0]   payload_index;
  logic                ctrl_write;
  logic [CCNT_W-1:0]   ctrl_index;
  logic [PCNT_W-1:0]   packet_length;
  logic [CCNT_W-1:0]   ctrl_length;
  logic                debug_byte_seen;
  logic                cfg_ready;

  int mismatch_count;
  int awaited_count;
  int checked_count;

  // Stimulus bookkeeping
  int      bytes_sent   = 0;
  int      cur_limit    = 512;
  int      limits_set   = 0;
  bit      rx_steady    = 1'b0;
  bit      pop_steady   = 1'b0;
  byte_q_t dbg_bytes;
  byte_q_t frame;

  datagram_and_debug_packet_deframer_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .push              (push),
    .full              (full),
    .rx_byte_i         (rx_byte),
    .empty             (empty),
    .pop               (pop),
    .event_res_o       (event_res),
    .data_byte_o       (data_byte),
    .payload_write_o   (payload_write),
    .payload_index_o   (payload_index),
    .ctrl_write_o      (ctrl_write),
    .ctrl_index_o      (ctrl_index),
    .packet_length_o   (packet_length),
    .ctrl_length_o     (ctrl_length),
    .debug_byte_seen_o (debug_byte_seen),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data)
  );

  deframer_monitor u_monitor (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .push              (push),
    .full              (full),
    .rx_byte_i         (rx_byte),
    .empty             (empty),
    .pop               (pop),
    .event_res_o       (event_res),
    .data_byte_o       (data_byte),
    .payload_write_o   (payload_write),
    .payload_index_o   (payload_index),
    .ctrl_write_o      (ctrl_write),
    .ctrl_index_o      (ctrl_index),
    .packet_length_o   (packet_length),
    .ctrl_length_o     (ctrl_length),
    .debug_byte_seen_o (debug_byte_seen),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatch_count),
    .awaited_count_o   (awaited_count),
    .checked_count_o   (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next request; a steady stretch has none
  function automatic int draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic int cap(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Checksum digit, upper or lower case at random
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  // Push one byte request and return at the edge where it is taken.
  // Leave push high: the next call either keeps it up or drops it for a gap,
  // so push never gets two assignments in one time step.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(rx_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    // full only moves at a rising edge, so the value at the falling edge is
    // the one the block sees at the next rising edge
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [15:0] len);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
  endtask

  // Send a length header and the body behind it
  task automatic send_datagram(input byte_q_t body);
    rx_steady = ($urandom_range(0, 3) == 0);
    send_header(16'(body.size()));
    foreach (body[i]) push_byte(body[i]);
  endtask

  // Append one debugger packet to the debug byte stream
  task automatic queue_packet(input int len, input pkt_flavor_e flavor);
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] told;
    sum = 8'h00;
    dbg_bytes.push_back(CH_DOLLAR);
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      // keep the payload well formed: a hash would end it early
      if (b == CH_HASH) b = 8'h22;
      dbg_bytes.push_back(b);
      sum = sum + b;
    end
    dbg_bytes.push_back(CH_HASH);
    case (flavor)
      PK_GOOD:    told = sum;
      PK_BAD_SUM: told = sum ^ 8'($urandom_range(1, 255));
      default:    told = sum;
    endcase
    if (flavor == PK_WILD_DIGITS) begin
      // any byte in either digit slot: valid or not, matching or not
      dbg_bytes.push_back(8'($urandom_range(0, 255)));
      dbg_bytes.push_back($urandom_range(0, 1) ? hex_char(told[3:0])
                                               : 8'($urandom_range(0, 255)));
    end else begin
      dbg_bytes.push_back(hex_char(told[7:4]));
      dbg_bytes.push_back(hex_char(told[3:0]));
    end
  endtask

  // A few items of debug traffic: mostly packets, some interrupts and noise
  task automatic queue_debug_traffic();
    int pick;
    repeat ($urandom_range(1, 3)) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      queue_packet($urandom_range(0, 16), PK_GOOD);
      else if (pick < 75) queue_packet($urandom_range(0, 16), PK_BAD_SUM);
      else if (pick < 83) queue_packet($urandom_range(0, 8), PK_WILD_DIGITS);
      else if (pick < 91) dbg_bytes.push_back(CH_INTR);
      else repeat ($urandom_range(1, 3)) dbg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Cut the debug stream into datagrams no longer than the current limit
  task automatic flush_debug();
    int      most;
    byte_q_t chunk;
    while (dbg_bytes.size() > 0) begin
      most = cap(cap(dbg_bytes.size(), cur_limit), 48);
      chunk.delete();
      repeat ($urandom_range(1, most)) chunk.push_back(dbg_bytes.pop_front());
      send_datagram(chunk);
    end
  endtask

  // Random traffic: well-formed datagrams mostly, with resyncs and noise
  task automatic random_traffic(input int n);
    int      stop_at;
    int      pick;
    int      len;
    byte_q_t body;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      // with a zero limit only empty datagrams and resyncs are possible
      if (cur_limit == 0) pick = (pick < 50) ? 72 : 80;
      if (pick < 55) begin
        queue_debug_traffic();
        flush_debug();
      end else if (pick < 70) begin
        // control datagram, short ones and overflowing ones included
        len = $urandom_range(1, cap(cur_limit, 30));
        body.delete();
        body.push_back(CH_CTRL);
        repeat (len - 1) body.push_back(8'($urandom_range(0, 255)));
        send_datagram(body);
      end else if (pick < 78 && cur_limit < 65535) begin
        send_header(16'($urandom_range(cur_limit + 1, 65535)));
      end else if (pick < 84) begin
        send_header(16'd0);
      end else begin
        // datagram of arbitrary bytes
        len = $urandom_range(1, cap(cur_limit, 12));
        body.delete();
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
        send_datagram(body);
      end
    end
  endtask

  // Write the length limit once everything in flight has come out
  task automatic write_limit(input logic [15:0] v);
    push <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    // let the pipe settle before the write
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = v;
    limits_set++;
  endtask

  // Result side: pop with random stalls and steady stretches
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap(pop_steady);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
      while (empty) @(negedge clk);
      @(posedge clk);
      if ($urandom_range(0, 24) == 0) pop_steady = !pop_steady;
    end
  end

  // Byte and config side
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty datagram, short control, minimal control, a debug
    // datagram with an interrupt, a stray byte, a plain good packet, a good
    // packet whose invalid low digit reads as 0xFF, one whose invalid high
    // digit reads as 0xF0, then an oversized length
    send_header(16'd0);
    frame = {CH_CTRL};
    send_datagram(frame);
    frame = {CH_CTRL, 8'hFF};
    send_datagram(frame);
    frame = {CH_INTR, "x", CH_DOLLAR, "a", CH_HASH, "6", "1",
             CH_DOLLAR, 8'hFF, CH_HASH, "F", "g",
             CH_DOLLAR, 8'hF5, CH_HASH, "z", "5"};
    send_datagram(frame);
    send_header(16'hFFFF);

    random_traffic(200);

    write_limit(16'd0);
    random_traffic(40);

    // widest limit: also run one packet past the payload buffer
    write_limit(16'hFFFF);
    queue_packet(390 + $urandom_range(0, 10), PK_GOOD);
    flush_debug();
    random_traffic(100);

    write_limit(16'($urandom_range(1, 65534)));
    random_traffic(120);

    write_limit(16'd3);
    random_traffic(100);

    write_limit(16'($urandom_range(24, 600)));
    random_traffic(150);

    // drain and let the pipe run dry
    push <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d bytes, %0d results checked, %0d limit writes",
             bytes_sent, checked_count, limits_set);
    $display("limits included 0 and 65535; packets, interrupts, control and resyncs");
    if (mismatch_count == 0) begin
      $display("tb_datagram_and_debug_packet_deframer_top: done, clean");
    end else begin
      $display("tb_datagram_and_debug_packet_deframer_top: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_datagram_and_debug_packet_deframer_top: done, errors");
    $finish;
  end

endmodule
